// ===== hdl/gcf_pkg.sv =====
// shared types and constants of the gamma colour crossfade unit
// request and result structs, lane control struct, register indexes
// no dependencies
package gcf_pkg;

  // field widths
  localparam int ColorW  = 8;
  localparam int LinW    = 16;
  localparam int FrameW  = 6;
  localparam int CountW  = 7;

  // per-lane divider: 17-bit dividend, 7-bit divisor, one bit a step
  localparam int MagW     = LinW + 1;
  localparam int DivW     = 7;
  localparam int DivSteps = MagW;

  // frame count saturation
  localparam logic [CountW-1:0] MaxFrames = 7'd64;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgFrameCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGammaEn    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInterpMode = 2'd2;

  // request: start and end colour
  typedef struct packed {
    logic [ColorW-1:0] start_r;
    logic [ColorW-1:0] start_g;
    logic [ColorW-1:0] start_b;
    logic [ColorW-1:0] end_r;
    logic [ColorW-1:0] end_g;
    logic [ColorW-1:0] end_b;
  } gcf_in_t;

  // result: one frame of the transition
  typedef struct packed {
    logic [FrameW-1:0] frame_index;
    logic [ColorW-1:0] out_r;
    logic [ColorW-1:0] out_g;
    logic [ColorW-1:0] out_b;
    logic              last_frame;
  } gcf_out_t;

  // sequencer to lanes
  typedef struct packed {
    logic              load;
    logic              prep;
    logic              div_step;
    logic              init;
    logic              step;
    logic              adv;
    logic              lin;
    logic              mode;
    logic [CountW-1:0] frames;
  } gcf_lane_ctl_t;

  // frame tag that travels beside the lane pipeline
  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] index;
    logic              last;
  } gcf_tag_t;

endpackage

// ===== hdl/gcf_lane.sv =====
// one colour channel of the crossfade: gamma lookup, restoring divider,
// quotient/remainder accumulator and inverse gamma rom read
// depends on gcf_pkg
module gcf_lane import gcf_pkg::*; #(
  parameter int InvEntries = 1024
) (
  input  logic                clk_i,
  input  gcf_lane_ctl_t       ctl_i,
  input  logic [ColorW-1:0]   start_val_i,
  input  logic [ColorW-1:0]   end_val_i,
  output logic [ColorW-1:0]   colour_o
);

  localparam int IdxW  = $clog2(InvEntries);
  localparam int ProdW = LinW + $clog2(InvEntries + 1);

  typedef logic [191:0] big_t;
  typedef logic [255:0][LinW-1:0] fwd_rom_t;
  typedef logic [InvEntries-1:0][ColorW-1:0] inv_rom_t;

  // a^p * b^q, exact at elaboration
  function automatic big_t pow_prod(input big_t a, input int p, input big_t b, input int q);
    big_t r;
    int   n;
    r = big_t'(1);
    for (n = 0; n < p; n++) r = r * a;
    for (n = 0; n < q; n++) r = r * b;
    return r;
  endfunction

  // round(65535*(x/255)^2.2): largest v with (2v-1)^5*255^11 <= 131070^5*x^11
  function automatic fwd_rom_t build_fwd();
    fwd_rom_t        tab;
    big_t            rhs;
    logic [LinW-1:0] v;
    logic [LinW-1:0] cand;
    int              x;
    int              k;
    for (x = 0; x < 256; x++) begin
      rhs = pow_prod(big_t'(131070), 5, big_t'(x), 11);
      v   = '0;
      for (k = LinW - 1; k >= 0; k--) begin
        cand = v | (LinW'(1) << k);
        if (pow_prod(big_t'({cand, 1'b0}) - big_t'(1), 5, big_t'(255), 11) <= rhs) begin
          v = cand;
        end
      end
      tab[x] = v;
    end
    return tab;
  endfunction

  // round(255*(L/65535)^(1/2.2)) at L = floor(i*65536/entries)
  function automatic inv_rom_t build_inv();
    inv_rom_t          tab;
    big_t              rhs;
    big_t              lv;
    logic [ColorW-1:0] v;
    logic [ColorW-1:0] cand;
    int                i;
    int                k;
    for (i = 0; i < InvEntries; i++) begin
      lv  = big_t'((i * 65536) / InvEntries);
      rhs = pow_prod(lv, 5, big_t'(510), 11);
      v   = '0;
      for (k = ColorW - 1; k >= 0; k--) begin
        cand = v | (ColorW'(1) << k);
        if (pow_prod(big_t'({cand, 1'b0}) - big_t'(1), 11, big_t'(65535), 5) <= rhs) begin
          v = cand;
        end
      end
      tab[i] = v;
    end
    return tab;
  endfunction

  localparam fwd_rom_t FwdRom = build_fwd();
  localparam inv_rom_t InvRom = build_inv();

  logic [ColorW-1:0] s_q, e_q;
  logic [LinW-1:0]   base_q, base_d;
  logic [LinW-1:0]   mag_q, mag_d;
  logic              neg_q, neg_d;
  logic [LinW-1:0]   lin_end;
  logic [CountW-1:0] frames_m1;
  logic [DivW-1:0]   dvsr_q, dvsr_d;
  logic [MagW-1:0]   dquo_q, dquo_d;
  logic [DivW-1:0]   drem_q;
  logic [DivW:0]     div_t, div_diff;
  logic              div_ge;
  logic [LinW-1:0]   acc_q;
  logic [DivW-1:0]   accr_q;
  logic [DivW:0]     r_sum, r_diff;
  logic              r_wrap;
  logic [LinW-1:0]   val_d, val_q;
  logic [ProdW-1:0]  prod;
  logic [IdxW-1:0]   idx_q;
  logic [ColorW-1:0] low2_q, low3_q;
  logic [ColorW-1:0] inv_q;

  // capture request colours
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      s_q <= start_val_i;
      e_q <= end_val_i;
    end
  end

  // endpoints in colour or linear light, difference as sign and magnitude
  always_comb begin
    base_d    = ctl_i.lin ? FwdRom[s_q] : LinW'(s_q);
    lin_end   = ctl_i.lin ? FwdRom[e_q] : LinW'(e_q);
    neg_d     = lin_end < base_d;
    mag_d     = neg_d ? (base_d - lin_end) : (lin_end - base_d);
    frames_m1 = ctl_i.frames - CountW'(1);
    // rounded mode divides 2|d| by 2(n-1), truncated mode |d| by n
    dquo_d    = ctl_i.mode ? {1'b0, mag_d} : {mag_d, 1'b0};
    dvsr_d    = ctl_i.mode ? DivW'(ctl_i.frames) : {frames_m1[DivW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      base_q <= base_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      dvsr_q <= dvsr_d;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign div_t    = {drem_q, dquo_q[MagW-1]};
  assign div_ge   = div_t >= {1'b0, dvsr_q};
  assign div_diff = div_t - {1'b0, dvsr_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      dquo_q <= dquo_d;
      drem_q <= '0;
    end else if (ctl_i.div_step) begin
      dquo_q <= {dquo_q[MagW-2:0], div_ge};
      drem_q <= div_ge ? div_diff[DivW-1:0] : div_t[DivW-1:0];
    end
  end

  // per-frame quotient: add step quotient, carry on remainder overflow
  assign r_sum  = {1'b0, accr_q} + {1'b0, drem_q};
  assign r_wrap = r_sum >= {1'b0, dvsr_q};
  assign r_diff = r_sum - {1'b0, dvsr_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      if (ctl_i.mode) begin
        acc_q  <= dquo_q[LinW-1:0];
        accr_q <= drem_q;
      end else if (ctl_i.frames == CountW'(1)) begin
        // single frame lands on the end value
        acc_q  <= mag_q;
        accr_q <= '0;
      end else begin
        // half the divisor seeds round half away
        acc_q  <= '0;
        accr_q <= DivW'(frames_m1);
      end
    end else if (ctl_i.step) begin
      acc_q  <= acc_q + dquo_q[LinW-1:0] + LinW'(r_wrap);
      accr_q <= r_wrap ? r_diff[DivW-1:0] : r_sum[DivW-1:0];
    end
  end

  // frame value, rom index, rom read
  assign val_d = neg_q ? (base_q - acc_q) : (base_q + acc_q);
  assign prod  = ProdW'(val_q) * ProdW'(InvEntries);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      val_q  <= val_d;
      idx_q  <= prod[LinW +: IdxW];
      low2_q <= val_q[ColorW-1:0];
      inv_q  <= InvRom[idx_q];
      low3_q <= low2_q;
    end
  end

  assign colour_o = ctl_i.lin ? inv_q : low3_q;

endmodule

// ===== hdl/gcf_ctrl.sv =====
// sequencer of the crossfade: request capture, divide phase, frame generation
// and the frame tag pipeline beside the lanes
// depends on gcf_pkg
module gcf_ctrl import gcf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              adv_i,
  input  logic [CountW-1:0] frame_count_i,
  input  logic              gamma_en_i,
  input  logic              interp_mode_i,
  output gcf_lane_ctl_t     ctl_o,
  output logic              busy_o,
  output gcf_tag_t          tag_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StInit = 3'd3;
  localparam logic [2:0] StRun  = 3'd4;

  localparam int CntW = $clog2(DivSteps);
  localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [CountW-1:0] frames;
  logic              run_fire;
  logic              at_last;
  gcf_tag_t          t1_q, t2_q, t3_q, t1_d;

  // frame count: zero means one, large values saturate
  always_comb begin
    if (frame_count_i == '0) begin
      frames = CountW'(1);
    end else if (frame_count_i > MaxFrames) begin
      frames = MaxFrames;
    end else begin
      frames = frame_count_i;
    end
  end

  assign run_fire = (state_q == StRun) && adv_i;
  assign at_last  = (CountW'(frame_q) == (frames - CountW'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    frame_d = frame_q;
    case (state_q)
      StIdle: begin
        if (in_fire_i) state_d = StPrep;
      end
      StPrep: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) state_d = StInit;
      end
      StInit: begin
        frame_d = '0;
        state_d = StRun;
      end
      StRun: begin
        if (adv_i) begin
          frame_d = frame_q + FrameW'(1);
          if (at_last) state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      frame_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      frame_q <= frame_d;
    end
  end

  // frame tags follow the three lane stages
  assign t1_d = '{valid: run_fire, index: frame_q, last: at_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
    end else if (adv_i) begin
      t1_q <= t1_d;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  // lane control
  always_comb begin
    ctl_o.load     = in_fire_i;
    ctl_o.prep     = (state_q == StPrep);
    ctl_o.div_step = (state_q == StDiv);
    ctl_o.init     = (state_q == StInit);
    ctl_o.step     = run_fire;
    ctl_o.adv      = adv_i;
    ctl_o.lin      = gamma_en_i & ~interp_mode_i;
    ctl_o.mode     = interp_mode_i;
    ctl_o.frames   = frames;
  end

  assign busy_o = (state_q != StIdle);
  assign tag_o  = t3_q;

`ifndef SYNTHESIS
  // an accepted request always starts with the lookup cycle
  a_fire_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> (state_q == StPrep))
    else $error("request accepted outside idle");

  // the divider runs its full step count before seeding
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == CntLast) |=> (state_q == StInit))
    else $error("divide phase length wrong");

  // the final frame leaves tagged and the sequencer returns to idle
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_fire && at_last) |=> (state_q == StIdle && t1_q.valid && t1_q.last))
    else $error("final frame not tagged");

  // a held output freezes the tag pipeline
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(t3_q) && $stable(t2_q)))
    else $error("tag pipeline moved while held");
`endif

endmodule

// ===== hdl/gamma_color_crossfade_unit.sv =====
// gamma colour crossfade unit: three colour lanes, sequencer, merging output register
// a request runs the 17-step restoring divider in each lane and then yields N frames (N after
// saturation), one frame a cycle from the lane accumulators while the output is not stalled
// reset (rst_ni, async, active low): frame_count 20, gamma on, mode 0, pipeline empty
// depends on gcf_pkg, gcf_lane, gcf_ctrl
module gamma_color_crossfade_unit import gcf_pkg::*; #(
  parameter int InvGammaEntries = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gcf_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gcf_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int Lanes = 3;

  logic [CountW-1:0] frame_count_q;
  logic              gamma_en_q;
  logic              interp_mode_q;
  logic              busy;
  logic              in_fire;
  logic              adv;
  gcf_lane_ctl_t     lane_ctl;
  gcf_tag_t          tag;
  logic [Lanes-1:0][ColorW-1:0] lane_start;
  logic [Lanes-1:0][ColorW-1:0] lane_end;
  logic [Lanes-1:0][ColorW-1:0] lane_colour;
  logic              out_valid_q;
  gcf_out_t          out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= 7'd20;
      gamma_en_q    <= 1'b1;
      interp_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFrameCount: frame_count_q <= cfg_wdata_i[CountW-1:0];
        CfgGammaEn:    gamma_en_q    <= cfg_wdata_i[0];
        CfgInterpMode: interp_mode_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // request handshake and pipeline advance
  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign adv        = !out_valid_q || !out_stall_i;

  gcf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .adv_i         (adv),
    .frame_count_i (frame_count_q),
    .gamma_en_i    (gamma_en_q),
    .interp_mode_i (interp_mode_q),
    .ctl_o         (lane_ctl),
    .busy_o        (busy),
    .tag_o         (tag)
  );

  // red, green, blue lanes
  assign lane_start[0] = in_data_i.start_r;
  assign lane_start[1] = in_data_i.start_g;
  assign lane_start[2] = in_data_i.start_b;
  assign lane_end[0]   = in_data_i.end_r;
  assign lane_end[1]   = in_data_i.end_g;
  assign lane_end[2]   = in_data_i.end_b;

  for (genvar c = 0; c < Lanes; c++) begin : g_lane
    gcf_lane #(
      .InvEntries (InvGammaEntries)
    ) u_lane (
      .clk_i       (clk_i),
      .ctl_i       (lane_ctl),
      .start_val_i (lane_start[c]),
      .end_val_i   (lane_end[c]),
      .colour_o    (lane_colour[c])
    );
  end

  // merge lanes and tag into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= '{frame_index: tag.index,
                 out_r:       lane_colour[0],
                 out_g:       lane_colour[1],
                 out_b:       lane_colour[2],
                 last_frame:  tag.last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== bench/tb_gamma_color_crossfade_unit.sv =====
// testbench for gamma_color_crossfade_unit: directed and random colour transitions
// with independent frame predictor, random idling on both channels and register phases
// depends on gcf_pkg and the unit rtl
`timescale 1ns / 100ps

module tb_gamma_color_crossfade_unit;
  import gcf_pkg::*;

  localparam int INV_ENTRIES  = 1024;
  localparam int RAND_REQS    = 320;
  localparam int SETTLE       = 30;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  gcf_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  gcf_out_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // shadow registers, reset values of the unit
  logic [CountW-1:0] frames_cfg = 7'd20;
  logic              gamma_cfg  = 1'b1;
  logic              mode_cfg   = 1'b0;

  // gamma lookup tables rebuilt here from exact integer comparisons
  logic [LinW-1:0]   lin_of_code [256];
  logic [ColorW-1:0] code_of_lin [INV_ENTRIES];

  gcf_in_t  pending_reqs [$];
  gcf_out_t frames_due [$];

  logic no_idle = 1'b0;
  logic offer_next;
  int   gap_left, send_wait = 0;
  int   hold_left, recv_wait = 0;
  int   mismatches = 0;
  int   reqs_pushed = 0;
  int   reqs_taken = 0;
  int   frames_seen = 0;
  int   reg_writes = 0;
  int   cycle_cnt = 0;

  gamma_color_crossfade_unit #(.InvGammaEntries(INV_ENTRIES)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // a^p * b^q, wide enough for both table searches
  function automatic logic [255:0] pow_prod(int unsigned a, int unsigned p,
                                            int unsigned b, int unsigned q);
    logic [255:0] acc;
    acc = 256'd1;
    for (int k = 0; k < p; k++) acc = acc * 256'(a);
    for (int k = 0; k < q; k++) acc = acc * 256'(b);
    return acc;
  endfunction

  // forward table round(65535*(x/255)^2.2), inverse round(255*(L/65535)^(1/2.2))
  task automatic build_gamma_luts();
    logic [255:0] bound;
    int unsigned lo, hi, mid, lv;
    for (int x = 0; x < 256; x++) begin
      bound = pow_prod(131070, 5, x, 11);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (pow_prod(2 * mid - 1, 5, 255, 11) <= bound) lo = mid;
        else hi = mid - 1;
      end
      lin_of_code[x] = LinW'(lo);
    end
    for (int i = 0; i < INV_ENTRIES; i++) begin
      lv = (i * 65536) / INV_ENTRIES;
      bound = pow_prod(lv, 5, 510, 11);
      lo = 0;
      hi = 255;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (pow_prod(2 * mid - 1, 11, 65535, 5) <= bound) lo = mid;
        else hi = mid - 1;
      end
      code_of_lin[i] = ColorW'(lo);
    end
  endtask

  // quotient rounded half away from zero, den positive
  function automatic int div_round_away(int num, int den);
    if (num < 0) return -((2 * (-num) + den) / (2 * den));
    return (2 * num + den) / (2 * den);
  endfunction

  // one colour channel of frame f out of n
  function automatic logic [ColorW-1:0] blend_channel(logic [ColorW-1:0] s,
                                                      logic [ColorW-1:0] e, int f, int n);
    int v, ls, le, idx;
    if (mode_cfg) begin
      // crossfade: start excluded, truncated, never gamma
      v = int'(s) + (int'(e) - int'(s)) * (f + 1) / n;
      return v[ColorW-1:0];
    end
    if (gamma_cfg) begin
      ls = int'(lin_of_code[s]);
      le = int'(lin_of_code[e]);
      v  = (n > 1) ? ls + div_round_away((le - ls) * f, n - 1) : le;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      idx = (v * INV_ENTRIES) >>> 16;
      if (idx >= INV_ENTRIES) idx = INV_ENTRIES - 1;
      return code_of_lin[idx];
    end
    v = (n > 1) ? int'(s) + div_round_away((int'(e) - int'(s)) * f, n - 1) : int'(e);
    return v[ColorW-1:0];
  endfunction

  // all frames a request will produce under the current registers
  task automatic queue_fade_frames(gcf_in_t req);
    gcf_out_t fr;
    int n;
    n = int'(frames_cfg);
    if (n == 0) n = 1;
    if (n > int'(MaxFrames)) n = int'(MaxFrames);
    for (int f = 0; f < n; f++) begin
      fr.frame_index = FrameW'(f);
      fr.out_r       = blend_channel(req.start_r, req.end_r, f, n);
      fr.out_g       = blend_channel(req.start_g, req.end_g, f, n);
      fr.out_b       = blend_channel(req.start_b, req.end_b, f, n);
      fr.last_frame  = (f == n - 1);
      frames_due.push_back(fr);
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // request driver, fed from pending_reqs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
    end else begin
      offer_next = in_valid_i;
      gap_left   = send_wait;
      if (in_valid_i && !in_stall_o) begin
        queue_fade_frames(in_data_i);
        reqs_taken++;
        offer_next = 1'b0;
      end
      if (!offer_next) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          in_data_i <= pending_reqs.pop_front();
          offer_next = 1'b1;
          gap_left   = no_idle ? 0 : $urandom_range(0, 7);
        end
      end
      send_wait  <= gap_left;
      in_valid_i <= offer_next;
    end
  end

  // frame monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   <= 0;
    end else begin
      hold_left = recv_wait;
      if (out_valid_o && !out_stall_i) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, actual idx %0d rgb %0d %0d %0d",
                   $time, out_data_o.frame_index, out_data_o.out_r, out_data_o.out_g,
                   out_data_o.out_b);
          mismatches++;
        end else begin
          automatic gcf_out_t want = frames_due.pop_front();
          check_field("frame_index", want.frame_index, out_data_o.frame_index);
          check_field("out_r", want.out_r, out_data_o.out_r);
          check_field("out_g", want.out_g, out_data_o.out_g);
          check_field("out_b", want.out_b, out_data_o.out_b);
          check_field("last_frame", want.last_frame, out_data_o.last_frame);
        end
        hold_left = no_idle ? 0 : $urandom_range(0, 7);
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
      end
      recv_wait   <= hold_left;
      out_stall_i <= (hold_left != 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CfgFrameCount: frames_cfg = data;
      CfgGammaEn:    gamma_cfg  = data[0];
      CfgInterpMode: mode_cfg   = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // one-bit registers get random upper bits, which must be ignored
  task automatic set_config(int frames, logic gamma, logic mode);
    write_reg(CfgFrameCount, CfgDataW'(frames));
    write_reg(CfgGammaEn, {(CfgDataW-1)'($urandom_range(0, 63)), gamma});
    write_reg(CfgInterpMode, {(CfgDataW-1)'($urandom_range(0, 63)), mode});
  endtask

  task automatic push_req(int sr, int sg, int sb, int er, int eg, int eb);
    gcf_in_t req;
    req = '{start_r: sr[7:0], start_g: sg[7:0], start_b: sb[7:0],
            end_r: er[7:0], end_g: eg[7:0], end_b: eb[7:0]};
    pending_reqs.push_back(req);
    reqs_pushed++;
  endtask

  // sender holds off until every request is taken and every frame has come back
  task automatic drain();
    while (reqs_taken != reqs_pushed || frames_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // levels weighted towards the extremes and the steep dark end of the curve
  function automatic int rand_level();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      2: return $urandom_range(0, 15);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int rand_frames();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 8);
      6, 7:             return $urandom_range(9, 32);
      8:                return $urandom_range(33, 64);
      default:          return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(65, 127);
    endcase
  endfunction

  initial begin
    int rand_sent, phase_len, sr, sg, sb;
    rand_sent = 0;
    build_gamma_luts();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset registers: 20 frames, gamma on, rounded mode
    push_req(0, 0, 0, 255, 255, 255);
    push_req(255, 255, 255, 0, 0, 0);
    push_req(1, 128, 254, 254, 127, 1);
    drain();

    // single frame emits the end colour
    set_config(1, 1'b1, 1'b0);
    push_req(10, 20, 30, 200, 100, 50);
    push_req(255, 0, 128, 0, 255, 7);
    drain();

    // zero frame count behaves as one, no gamma
    set_config(0, 1'b0, 1'b0);
    push_req(0, 255, 0, 255, 0, 255);
    push_req(77, 3, 190, 12, 250, 66);
    drain();

    // frame count saturates at the maximum; gamma ignored in crossfade mode
    set_config(127, 1'b1, 1'b1);
    push_req(0, 0, 0, 255, 255, 255);
    push_req(255, 128, 0, 0, 128, 255);
    drain();

    // maximum frames, rounded mode without gamma
    set_config(64, 1'b0, 1'b0);
    push_req(255, 0, 0, 0, 0, 255);
    push_req(3, 250, 77, 9, 11, 200);
    drain();

    // write to an unknown register index leaves everything alone
    set_config(2, 1'b1, 1'b1);
    write_reg(CfgUnused, 7'h7f);
    push_req(0, 255, 17, 255, 0, 18);
    push_req(100, 100, 100, 100, 100, 100);
    drain();

    // just above the maximum, gamma on with dark and bright small steps
    set_config(65, 1'b1, 1'b0);
    push_req(0, 0, 0, 1, 2, 3);
    push_req(255, 255, 255, 254, 253, 252);
    drain();

    set_config(3, 1'b0, 1'b1);
    push_req(0, 255, 200, 255, 0, 10);
    drain();

    // random phases, each under its own register setting
    while (rand_sent < RAND_REQS) begin
      set_config(rand_frames(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) write_reg(CfgUnused, CfgDataW'($urandom));
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 25);
      for (int k = 0; k < phase_len; k++) begin
        sr = rand_level();
        sg = rand_level();
        sb = rand_level();
        if ($urandom_range(0, 7) == 0) push_req(sr, sg, sb, sr, sg, sb);
        else push_req(sr, sg, sb, rand_level(), rand_level(), rand_level());
      end
      rand_sent += phase_len;
      drain();
      no_idle = 1'b0;
    end

    repeat (SETTLE) @(posedge clk_i);
    if (frames_due.size() != 0) begin
      $display("%0t: %0d frames never arrived", $time, frames_due.size());
      mismatches++;
    end
    $display("run covered %0d requests and %0d checked frames over %0d register writes",
             reqs_taken, frames_seen, reg_writes);
    $display("mismatches found: %0d", mismatches);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
